// ----- src/sfb_pkg.sv -----
// Shared types, constants and helper functions for the split-flap board animator.
// No dependencies; imported by sfb_ram users and the top level.
package sfb_pkg;

	localparam int BOARD_ROWS  = 10;
	localparam int BOARD_COLS  = 24;
	localparam int CELL_SIZE   = 16;
	localparam int GLYPH_COUNT = 37;
	localparam int NCELLS      = BOARD_ROWS * BOARD_COLS;
	localparam int NFONT       = (GLYPH_COUNT + 1) * CELL_SIZE;
	localparam int CELL_AW     = $clog2(NCELLS);
	localparam int FONT_AW     = $clog2(NFONT);
	localparam int CODE_W      = 6;
	localparam int DIFF_W      = $clog2(NCELLS + 1);

	localparam logic [3:0] PHASE_IDLE = 4'd8;
	localparam logic [3:0] PHASE_LAST = 4'd7;

	localparam logic [2:0] REQ_FONT  = 3'd0;
	localparam logic [2:0] REQ_PUT   = 3'd1;
	localparam logic [2:0] REQ_CLEAR = 3'd2;
	localparam logic [2:0] REQ_TICK  = 3'd3;
	localparam logic [2:0] REQ_QUERY = 3'd4;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [3:0]  cell_row;
		logic [4:0]  cell_col;
		logic [3:0]  line_index;
		logic [5:0]  glyph_index;
		logic [15:0] font_bits;
		logic [7:0]  ascii_char;
	} req_t;

	typedef struct packed {
		logic [16:0] line_bits;
		logic [8:0]  line_x;
		logic [7:0]  line_y;
		logic [5:0]  cell_code;
		logic [3:0]  frame_phase;
		logic        busy_res;
	} rsp_t;

	// Row and column of a cell flattened into the cell memory address.
	function automatic logic [CELL_AW-1:0] cell_addr(input logic [3:0] row,
		input logic [4:0] col);
		return CELL_AW'(row * BOARD_COLS + col);
	endfunction

	function automatic logic [CODE_W-1:0] next_code(input logic [CODE_W-1:0] c);
		logic [CODE_W-1:0] r;
		begin
			if (c >= CODE_W'(GLYPH_COUNT - 1)) r = '0;
			else r = c + 1'b1;
			return r;
		end
	endfunction

	function automatic logic [CODE_W-1:0] map_char(input logic [7:0] ch);
		logic [CODE_W-1:0] code;
		begin
			code = '0;
			if (ch >= 8'h41 && ch <= 8'h5a) code = CODE_W'(ch - 8'h40);
			else if (ch >= 8'h61 && ch <= 8'h7a) code = CODE_W'(ch - 8'h60);
			else if (ch >= 8'h30 && ch <= 8'h39) code = CODE_W'(ch - 8'h30 + 8'd27);
			if (code >= CODE_W'(GLYPH_COUNT)) code = '0;
			return code;
		end
	endfunction

	// Height of the upper source half during a flip frame.
	function automatic logic [3:0] k_upper(input logic [2:0] p);
		logic [3:0] k;
		begin
			case (p)
				3'd0: k = 4'd7;
				3'd1: k = 4'd6;
				3'd2: k = 4'd4;
				3'd3: k = 4'd1;
				default: k = 4'd0;
			endcase
			return k;
		end
	endfunction

	// Height of the lower destination half during a flip frame.
	function automatic logic [3:0] k_lower(input logic [2:0] p);
		logic [3:0] k;
		begin
			case (p)
				3'd3: k = 4'd1;
				3'd4: k = 4'd4;
				3'd5: k = 4'd6;
				3'd6: k = 4'd7;
				3'd7: k = 4'd8;
				default: k = 4'd0;
			endcase
			return k;
		end
	endfunction

	// Font row (i*8)/k for a squashed half of height k.
	function automatic logic [3:0] squash_row(input logic [3:0] k, input logic [3:0] i);
		logic [3:0] r;
		begin
			case (k)
				4'd4: r = {i[2:0], 1'b0};
				4'd6: begin
					case (i)
						4'd3: r = 4'd4;
						4'd4: r = 4'd5;
						4'd5: r = 4'd6;
						default: r = i;
					endcase
				end
				4'd7, 4'd8: r = i;
				default: r = 4'd0;
			endcase
			return r;
		end
	endfunction

	// For a flipping cell: which glyph (1 = destination) and which font row
	// land on pixel line y at frame p.
	function automatic logic [4:0] flip_line(input logic [2:0] p, input logic [3:0] y);
		logic [3:0] ku;
		logic [3:0] kl;
		logic [4:0] r;
		begin
			ku = k_upper(p);
			kl = k_lower(p);
			if (!y[3]) begin
				if (ku != 4'd0 && y >= 4'd8 - ku) r = {1'b0, squash_row(ku, y + ku - 4'd8)};
				else r = {1'b1, y};
			end else begin
				// The bound reaches 16 in the last frame, so it is compared in five bits.
				if ({1'b0, y} < 5'd8 + {1'b0, kl}) r = {1'b1, 4'd15 - squash_row(kl, 4'd7 + kl - y)};
				else r = {1'b0, y};
			end
			return r;
		end
	endfunction

endpackage

// ----- src/sfb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sfb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- src/split_flap_board_animator.sv -----
// Split-flap board animator top level: request sequencer, cell and font memories.
// Depends on sfb_pkg and sfb_ram.
//
// The block takes one request beat at a time and returns exactly one result beat
// for each. A font load and a tick that does not end a flip go from acceptance
// straight to the output state; a put passes the cell state on the way, and a line
// query the cell state and then the font state. The output register is loaded in
// the cycle before the earliest acceptance of the next request. A clear, and a tick
// in frame seven, sweep the whole cell memory through its single read port, one
// cell per cycle. Cell state (displayed and target code of each cell) lives in one
// memory word per cell; a valid bit per cell, cleared by reset, makes unwritten
// cells read as blank, so no clearing pass is needed after reset. The font lives in
// a second memory that has no reset and must be loaded before it is queried. A
// running count of animated cells whose displayed code differs from their target
// gives the busy flag without a board scan. A finished result waits in the result
// registers until the output register is free; the next request is accepted as
// soon as the sequencer is back in idle.
module split_flap_board_animator
	import sfb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CELL  = 3'd1;
	localparam logic [2:0] S_FONT  = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	localparam int CW = 2 * CODE_W;

	logic [2:0]        state_q;
	logic [3:0]        phase_q;
	logic [DIFF_W-1:0] diff_q;
	logic [DIFF_W-1:0] diff_next;
	logic [NCELLS-1:0] valid_q;
	logic              rd_vld_s1;

	req_t              req_q;
	logic              commit_q;

	logic [3:0]         sw_row_q;
	logic [4:0]         sw_col_q;
	logic               sw_issue_q;
	logic               sw_pend_s1;
	logic [CELL_AW-1:0] sw_addr_s1;
	logic               sw_anim_s1;
	logic               sw_last_s1;

	logic [16:0] res_bits_q;
	logic [8:0]  res_x_q;
	logic [7:0]  res_y_q;
	logic [5:0]  res_code_q;

	logic               cell_we;
	logic [CELL_AW-1:0] cell_waddr;
	logic [CW-1:0]      cell_wdata;
	logic [CELL_AW-1:0] cell_raddr;
	logic [CW-1:0]      cell_rdata;

	logic               font_we;
	logic [FONT_AW-1:0] font_raddr;
	logic [15:0]        font_rdata;

	logic [CODE_W-1:0] cur;
	logic [CODE_W-1:0] tgt;
	logic [CODE_W-1:0] ncur;
	logic [CODE_W-1:0] ntgt;
	logic              anim;
	logic              old_diff;
	logic              new_diff;
	logic              accept;
	logic              in_board;
	logic              sw_last;
	logic              flipping;
	logic [4:0]        fl_sel;
	logic [CODE_W-1:0] glyph;
	logic [3:0]        font_row;
	logic              out_free;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign in_board  = (req.cell_row < 4'(BOARD_ROWS)) && (req.cell_col < 5'(BOARD_COLS));
	assign out_free  = !rsp_valid || !rsp_stall;
	assign sw_last   = (sw_row_q == 4'(BOARD_ROWS - 1)) && (sw_col_q == 5'(BOARD_COLS - 1));

	// Read data of a never-written cell is taken as blank current and target.
	assign cur = rd_vld_s1 ? cell_rdata[CW-1:CODE_W] : '0;
	assign tgt = rd_vld_s1 ? cell_rdata[CODE_W-1:0] : '0;

	// Write-back of the cell word read in the cycle before: a put, or one sweep step.
	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = sw_addr_s1;
		anim       = sw_anim_s1;
		ncur       = cur;
		ntgt       = tgt;
		if (state_q == S_CELL && req_q.req_type == REQ_PUT) begin
			cell_we    = 1'b1;
			cell_waddr = cell_addr(req_q.cell_row, req_q.cell_col);
			anim       = (req_q.cell_col != 5'(BOARD_COLS - 1));
			ntgt       = map_char(req_q.ascii_char);
		end else if (state_q == S_SWEEP && sw_pend_s1) begin
			cell_we = 1'b1;
			if (!commit_q) ntgt = '0;
			else if (sw_anim_s1 && cur != tgt) ncur = next_code(cur);
		end
		cell_wdata = {ncur, ntgt};
		old_diff   = anim && (cur != tgt);
		new_diff   = anim && (ncur != ntgt);
		diff_next  = diff_q;
		if (cell_we) diff_next = diff_q - DIFF_W'(old_diff) + DIFF_W'(new_diff);
	end

	// Read address: the addressed cell at acceptance, or the sweep cursor.
	always_comb begin
		cell_raddr = cell_addr(req.cell_row, req.cell_col);
		if (state_q == S_SWEEP && sw_issue_q) begin
			cell_raddr = cell_addr(sw_row_q, sw_col_q);
		end
	end

	// A query picks the glyph and font row that show on its pixel line.
	always_comb begin
		flipping = (phase_q < PHASE_IDLE) && (req_q.cell_col != 5'(BOARD_COLS - 1)) &&
			(cur != tgt);
		fl_sel   = flip_line(phase_q[2:0], req_q.line_index);
		glyph    = cur;
		font_row = req_q.line_index;
		if (flipping) begin
			font_row = fl_sel[3:0];
			if (fl_sel[4]) glyph = next_code(cur);
		end
		font_raddr = {glyph, font_row};
	end

	assign font_we = accept && req.req_type == REQ_FONT &&
		req.glyph_index <= 6'(GLYPH_COUNT);

	sfb_ram #(.WIDTH(CW), .DEPTH(NCELLS)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	sfb_ram #(.WIDTH(16), .DEPTH(NFONT)) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (FONT_AW'({req.glyph_index, req.line_index})),
		.wdata (req.font_bits),
		.raddr (font_raddr),
		.rdata (font_rdata)
	);

	// Sequencer, phase, difference count and cell valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= PHASE_IDLE;
			diff_q     <= '0;
			valid_q    <= '0;
			rd_vld_s1  <= 1'b0;
			sw_issue_q <= 1'b0;
			sw_pend_s1 <= 1'b0;
			commit_q   <= 1'b0;
			rsp_valid  <= 1'b0;
		end else begin
			diff_q     <= diff_next;
			rd_vld_s1  <= valid_q[cell_raddr];
			sw_pend_s1 <= (state_q == S_SWEEP) && sw_issue_q;
			if (cell_we) valid_q[cell_waddr] <= 1'b1;
			if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_OUT;
						case (req.req_type)
							REQ_PUT, REQ_QUERY: begin
								if (in_board) state_q <= S_CELL;
							end
							REQ_CLEAR: begin
								commit_q   <= 1'b0;
								sw_issue_q <= 1'b1;
								state_q    <= S_SWEEP;
							end
							REQ_TICK: begin
								if (phase_q >= PHASE_IDLE) begin
									phase_q <= (diff_q != '0) ? 4'd0 : PHASE_IDLE;
								end else if (phase_q < PHASE_LAST) begin
									phase_q <= phase_q + 4'd1;
								end else begin
									commit_q   <= 1'b1;
									sw_issue_q <= 1'b1;
									state_q    <= S_SWEEP;
								end
							end
							default: ;
						endcase
					end
				end
				S_CELL: begin
					if (req_q.req_type == REQ_QUERY) state_q <= S_FONT;
					else state_q <= S_OUT;
				end
				S_FONT: state_q <= S_OUT;
				S_SWEEP: begin
					if (sw_issue_q && sw_last) sw_issue_q <= 1'b0;
					if (sw_pend_s1 && sw_last_s1) begin
						if (commit_q) phase_q <= (diff_next != '0) ? 4'd0 : PHASE_IDLE;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						rsp_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sweep cursor and its registered copy for the write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_row_q <= '0;
			sw_col_q <= '0;
		end else if (state_q == S_IDLE) begin
			sw_row_q <= '0;
			sw_col_q <= '0;
		end else if (state_q == S_SWEEP && sw_issue_q) begin
			if (sw_col_q == 5'(BOARD_COLS - 1)) begin
				sw_col_q <= '0;
				sw_row_q <= sw_row_q + 4'd1;
			end else begin
				sw_col_q <= sw_col_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		sw_addr_s1 <= cell_addr(sw_row_q, sw_col_q);
		sw_anim_s1 <= (sw_col_q != 5'(BOARD_COLS - 1));
		sw_last_s1 <= sw_last;
	end

	// Request capture and result fields; non-query results carry zeros.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= req;
			res_bits_q <= '0;
			res_x_q    <= '0;
			res_y_q    <= '0;
			res_code_q <= '0;
		end
		if (state_q == S_CELL && req_q.req_type == REQ_QUERY) begin
			res_code_q <= cur;
			res_x_q    <= 9'(req_q.cell_col * (CELL_SIZE + 3));
			res_y_q    <= {req_q.cell_row, req_q.line_index};
		end
		if (state_q == S_FONT) res_bits_q <= {font_rdata, 1'b1};
		if (state_q == S_OUT && out_free) begin
			rsp.line_bits   <= res_bits_q;
			rsp.line_x      <= res_x_q;
			rsp.line_y      <= res_y_q;
			rsp.cell_code   <= res_code_q;
			rsp.frame_phase <= phase_q;
			rsp.busy_res    <= (diff_q != '0);
		end
	end

endmodule
